// ----- hw/rtl/encoder_speed_ema_hysteresis_macros.svh -----
// Assertion macros for the encoder speed estimator.
// Used by the top level; no other dependencies.
`ifndef ENCODER_SPEED_EMA_HYSTERESIS_MACROS_SVH
`define ENCODER_SPEED_EMA_HYSTERESIS_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ESH_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ESH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/esh_pkg.sv -----
// Shared types and constants for the encoder speed estimator.
// No dependencies.
`default_nettype none

package esh_pkg;

  // Default values of the top-level parameters
  localparam int unsigned SPEED_FRAC_BITS_DEF = 12;
  localparam int unsigned SUM_WIDTH_DEF       = 24;

  // Fixed field widths
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned SPEED_W    = 31;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned ALPHA_W    = 11;
  localparam int unsigned THRESH_W   = 20;
  localparam int unsigned SMOOTH_W   = 32;

  // Fixed-point scaling
  localparam int unsigned RPS_FRAC_BITS   = 20;
  localparam int unsigned ALPHA_FRAC_BITS = 10;

  // Shared multiplier operand widths (signed)
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_WINDOWS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RPS_PER_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_STARTUP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_ATTACK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_RELEASE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_THRESHOLD = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_THRESHOLD  = 3'd7;

  // Register reset values
  localparam logic [7:0]          RST_WINDOW_TICKS    = 8'd5;
  localparam logic [7:0]          RST_RELEASE_WINDOWS = 8'd2;
  localparam logic [15:0]         RST_RPS_PER_COUNT   = 16'd14564;
  localparam logic [ALPHA_W-1:0]  RST_ALPHA_STARTUP   = 11'd1536;
  localparam logic [ALPHA_W-1:0]  RST_ALPHA_ATTACK    = 11'd26;
  localparam logic [ALPHA_W-1:0]  RST_ALPHA_RELEASE   = 11'd1536;
  localparam logic [THRESH_W-1:0] RST_START_THRESHOLD = 20'd2867;
  localparam logic [THRESH_W-1:0] RST_STOP_THRESHOLD  = 20'd1024;

  localparam logic [SPEED_W-1:0] MAG_MAX = {SPEED_W{1'b1}};

  typedef struct packed {
    logic [7:0]          window_ticks;
    logic [7:0]          release_windows;
    logic [15:0]         rps_per_count;
    logic [ALPHA_W-1:0]  alpha_startup;
    logic [ALPHA_W-1:0]  alpha_attack;
    logic [ALPHA_W-1:0]  alpha_release;
    logic [THRESH_W-1:0] start_threshold;
    logic [THRESH_W-1:0] stop_threshold;
  } cfg_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_rps;
    logic               is_moving;
    logic [SPEED_W-1:0] instant_rps;
    logic               window_done;
  } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/esh_if.sv -----
// Stream channels of the encoder speed estimator: tick input and result output.
// Depends on esh_pkg.
`default_nettype none

interface esh_in_if import esh_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TICK_W-1:0] tick_count;

  modport source (output valid, output tick_count, input ready);
  modport sink   (input valid, input tick_count, output ready);
endinterface

interface esh_out_if import esh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed_rps;
  logic               is_moving;
  logic [SPEED_W-1:0] instant_rps;
  logic               window_done;

  modport source (output valid, output speed_rps, output is_moving,
                  output instant_rps, output window_done, input ready);
  modport sink   (input valid, input speed_rps, input is_moving,
                  input instant_rps, input window_done, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/encoder_speed_ema_hysteresis.sv -----
// Encoder speed estimator: windowed count sum, asymmetric EMA, hysteresis.
// Channels tick_i (sink) and result_o (source), one plain config write port.
// A tick that does not close a window is accepted, then handed off; a tick
// that closes a window first passes through the datapath steps, as the
// single shared multiplier is used twice in sequence (count scaling, then the
// EMA product), each followed by its rounding/saturation step, and then the
// hysteresis decision. tick_i.ready is high only while the sequencer is idle.
// The result goes into an output register, so the sequencer is free again as
// soon as that register can take it; a stalled receiver holds the register,
// and the next finished item waits in the sequencer until the register drains.
// Every accepted tick gives exactly one result item.
// Reset (rst_ni low, asynchronous) restores all registers to their defaults,
// clears the window sum, tick and zero-window counts, the smoothed speed, the
// last instant speed and the moving flag, and empties the output register.
// Configuration is written with cfg_we_i/cfg_idx_i/cfg_wdata_i while idle.
// Depends on esh_pkg, esh_if, esh_core and the assertion macro header.
`default_nettype none
`include "encoder_speed_ema_hysteresis_macros.svh"

module encoder_speed_ema_hysteresis import esh_pkg::*; #(
  parameter int unsigned SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF,
  parameter int unsigned SUM_WIDTH       = SUM_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  esh_in_if.sink                tick_i,
  esh_out_if.source             result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t cfg_q;
  logic core_res_valid;
  logic core_res_ready;
  res_t core_res;
  logic out_valid_q;
  res_t out_data_q;

  // Config registers; every index of the 3-bit space maps to a register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_ticks    <= RST_WINDOW_TICKS;
      cfg_q.release_windows <= RST_RELEASE_WINDOWS;
      cfg_q.rps_per_count   <= RST_RPS_PER_COUNT;
      cfg_q.alpha_startup   <= RST_ALPHA_STARTUP;
      cfg_q.alpha_attack    <= RST_ALPHA_ATTACK;
      cfg_q.alpha_release   <= RST_ALPHA_RELEASE;
      cfg_q.start_threshold <= RST_START_THRESHOLD;
      cfg_q.stop_threshold  <= RST_STOP_THRESHOLD;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW_TICKS:    cfg_q.window_ticks    <= cfg_wdata_i[7:0];
        REG_RELEASE_WINDOWS: cfg_q.release_windows <= cfg_wdata_i[7:0];
        REG_RPS_PER_COUNT:   cfg_q.rps_per_count   <= cfg_wdata_i[15:0];
        REG_ALPHA_STARTUP:   cfg_q.alpha_startup   <= cfg_wdata_i[ALPHA_W-1:0];
        REG_ALPHA_ATTACK:    cfg_q.alpha_attack    <= cfg_wdata_i[ALPHA_W-1:0];
        REG_ALPHA_RELEASE:   cfg_q.alpha_release   <= cfg_wdata_i[ALPHA_W-1:0];
        REG_START_THRESHOLD: cfg_q.start_threshold <= cfg_wdata_i[THRESH_W-1:0];
        REG_STOP_THRESHOLD:  cfg_q.stop_threshold  <= cfg_wdata_i[THRESH_W-1:0];
      endcase
    end
  end

  esh_core #(
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
    .SUM_WIDTH       (SUM_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (tick_i.valid),
    .in_ready_o   (tick_i.ready),
    .tick_count_i (tick_i.tick_count),
    .res_valid_o  (core_res_valid),
    .res_ready_i  (core_res_ready),
    .res_o        (core_res)
  );

  // Output register: loads whenever empty or being drained this cycle
  assign core_res_ready = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_res_ready) begin
      out_valid_q <= core_res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_res_ready && core_res_valid) begin
      out_data_q <= core_res;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.speed_rps   = out_data_q.speed_rps;
  assign result_o.is_moving   = out_data_q.is_moving;
  assign result_o.instant_rps = out_data_q.instant_rps;
  assign result_o.window_done = out_data_q.window_done;

  // Sequencer must be busy the cycle after it takes a tick
  `ESH_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, tick_i.valid && tick_i.ready, !tick_i.ready, "tick accepted but sequencer still idle")
  // Stopped state always reports zero smoothed speed
  `ESH_ASSERT_IMPLIES(a_stopped_zero, clk_i, rst_ni, result_o.valid && !result_o.is_moving, result_o.speed_rps == '0, "nonzero speed while stopped")
  // A finished item handed off must appear in the output register
  `ESH_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, core_res_valid && core_res_ready, result_o.valid, "finished item not loaded into output register")

endmodule

`default_nettype wire

// ----- hw/rtl/esh_mul.sv -----
// Shared signed multiplier with registered product.
// Depends on esh_pkg.
`default_nettype none

module esh_mul import esh_pkg::*; (
  input  logic                      clk_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [PROD_W-1:0]  prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ----- hw/rtl/esh_core.sv -----
// Sequencer and datapath: window sum, speed scaling, EMA and hysteresis.
// Depends on esh_pkg and esh_mul.
`default_nettype none

module esh_core import esh_pkg::*; #(
  parameter int unsigned SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF,
  parameter int unsigned SUM_WIDTH       = SUM_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [TICK_W-1:0] tick_count_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output res_t                     res_o
);

  localparam int unsigned SCALE_SH = RPS_FRAC_BITS - SPEED_FRAC_BITS;
  localparam logic [PROD_W-1:0] SCALE_RND = PROD_W'(64'd1 << (SCALE_SH - 1));
  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
  localparam logic signed [SMOOTH_W-1:0] SM_MAX = {1'b0, {(SMOOTH_W-1){1'b1}}};
  localparam logic signed [SMOOTH_W-1:0] SM_MIN = {1'b1, {(SMOOTH_W-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] EMA_RND = PROD_W'(64'd1 << (ALPHA_FRAC_BITS - 1));

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCALE = 3'd1;  // |sum| * rps_per_count
  localparam logic [2:0] ST_MAG   = 3'd2;  // round, weight select, EMA difference
  localparam logic [2:0] ST_EMA   = 3'd3;  // alpha * (x - smoothed)
  localparam logic [2:0] ST_UPD   = 3'd4;  // finish EMA, saturate
  localparam logic [2:0] ST_HYST  = 3'd5;  // moving/stopped decision
  localparam logic [2:0] ST_OUT   = 3'd6;  // hand item to output register

  logic [2:0] state_q, state_d;

  logic signed [SUM_WIDTH-1:0] win_sum_q, win_sum_d;
  logic signed [SUM_WIDTH-1:0] cap_sum_q, cap_sum_d;
  logic [7:0]                  tick_idx_q, tick_idx_d;
  logic [7:0]                  zero_win_q, zero_win_d;
  logic signed [SMOOTH_W-1:0]  smooth_q, smooth_d;
  logic [SPEED_W-1:0]          inst_q, inst_d;
  logic                        moving_q, moving_d;
  logic                        done_q, done_d;
  logic signed [MUL_A_W-1:0]   diff_q, diff_d;
  logic [ALPHA_W-1:0]          alpha_q, alpha_d;

  // Window accumulate
  logic signed [SUM_WIDTH:0]   sum_ext;
  logic signed [SUM_WIDTH-1:0] sum_sat;
  logic                        win_close;

  // Shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic [SUM_WIDTH-1:0]       sum_abs;
  logic [PROD_W-1:0]          prod_rnd;
  logic [SPEED_W-1:0]         imag;
  logic signed [SMOOTH_W-1:0] x_val;
  logic [7:0]                 zw_next;
  logic signed [PROD_W-1:0]   ema_acc;
  logic signed [PROD_W-1:0]   ema_q10;
  logic [SMOOTH_W-1:0]        sm_mag;

  assign sum_ext   = (SUM_WIDTH+1)'(win_sum_q) + (SUM_WIDTH+1)'(tick_count_i);
  assign win_close = ({1'b0, tick_idx_q} + 9'd1) >= {1'b0, cfg_i.window_ticks};

  always_comb begin
    if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
      sum_sat = sum_ext[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_ext[SUM_WIDTH-1:0];
    end
  end

  assign sum_abs = cap_sum_q[SUM_WIDTH-1] ? (~cap_sum_q + SUM_WIDTH'(1)) : cap_sum_q;

  always_comb begin
    if (state_q == ST_SCALE) begin
      mul_a = $signed(MUL_A_W'(sum_abs));
      mul_b = $signed(MUL_B_W'(cfg_i.rps_per_count));
    end else begin
      mul_a = diff_q;
      mul_b = $signed(MUL_B_W'(alpha_q));
    end
  end

  esh_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Scaled magnitude with round half up, saturated to 31 bits
  assign prod_rnd = ($unsigned(prod) + SCALE_RND) >> SCALE_SH;
  assign imag     = (|prod_rnd[PROD_W-1:SPEED_W]) ? MAG_MAX : prod_rnd[SPEED_W-1:0];
  assign x_val    = cap_sum_q[SUM_WIDTH-1] ? -$signed({1'b0, imag}) : $signed({1'b0, imag});

  always_comb begin
    if (cap_sum_q == '0) begin
      zw_next = (zero_win_q < cfg_i.release_windows) ? zero_win_q + 8'd1 : zero_win_q;
    end else begin
      zw_next = '0;
    end
  end

  // alpha*x + (1-alpha)*s == alpha*(x - s) + s, all in Q.10 before the floor shift
  assign ema_acc = prod + (PROD_W'(smooth_q) <<< ALPHA_FRAC_BITS) + EMA_RND;
  assign ema_q10 = ema_acc >>> ALPHA_FRAC_BITS;

  assign sm_mag = smooth_q[SMOOTH_W-1] ? (~smooth_q + SMOOTH_W'(1)) : smooth_q;

  always_comb begin
    state_d    = state_q;
    win_sum_d  = win_sum_q;
    cap_sum_d  = cap_sum_q;
    tick_idx_d = tick_idx_q;
    zero_win_d = zero_win_q;
    smooth_d   = smooth_q;
    inst_d     = inst_q;
    moving_d   = moving_q;
    done_d     = done_q;
    diff_d     = diff_q;
    alpha_d    = alpha_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (win_close) begin
            cap_sum_d  = sum_sat;
            win_sum_d  = '0;
            tick_idx_d = '0;
            done_d     = 1'b1;
            state_d    = ST_SCALE;
          end else begin
            win_sum_d  = sum_sat;
            tick_idx_d = tick_idx_q + 8'd1;
            done_d     = 1'b0;
            state_d    = ST_OUT;
          end
        end
      end
      ST_SCALE: begin
        state_d = ST_MAG;
      end
      ST_MAG: begin
        inst_d     = imag;
        zero_win_d = zw_next;
        diff_d     = MUL_A_W'(x_val) - MUL_A_W'(smooth_q);
        if (zw_next >= cfg_i.release_windows) begin
          alpha_d = cfg_i.alpha_release;
        end else if (!moving_q) begin
          alpha_d = cfg_i.alpha_startup;
        end else begin
          alpha_d = cfg_i.alpha_attack;
        end
        state_d = ST_EMA;
      end
      ST_EMA: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (ema_q10[PROD_W-1:SMOOTH_W-1] != {(PROD_W-SMOOTH_W+1){ema_q10[PROD_W-1]}}) begin
          smooth_d = ema_q10[PROD_W-1] ? SM_MIN : SM_MAX;
        end else begin
          smooth_d = ema_q10[SMOOTH_W-1:0];
        end
        state_d = ST_HYST;
      end
      ST_HYST: begin
        if (!moving_q && (sm_mag > SMOOTH_W'(cfg_i.start_threshold))) begin
          moving_d = 1'b1;
        end else if (moving_q && (sm_mag < SMOOTH_W'(cfg_i.stop_threshold))) begin
          moving_d = 1'b0;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      win_sum_q  <= '0;
      tick_idx_q <= '0;
      zero_win_q <= '0;
      smooth_q   <= '0;
      inst_q     <= '0;
      moving_q   <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      win_sum_q  <= win_sum_d;
      tick_idx_q <= tick_idx_d;
      zero_win_q <= zero_win_d;
      smooth_q   <= smooth_d;
      inst_q     <= inst_d;
      moving_q   <= moving_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cap_sum_q <= cap_sum_d;
    diff_q    <= diff_d;
    alpha_q   <= alpha_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_OUT);

  always_comb begin
    res_o.is_moving   = moving_q;
    res_o.instant_rps = inst_q;
    res_o.window_done = done_q;
    if (!moving_q) begin
      res_o.speed_rps = '0;
    end else if (sm_mag[SMOOTH_W-1]) begin
      res_o.speed_rps = MAG_MAX;
    end else begin
      res_o.speed_rps = sm_mag[SPEED_W-1:0];
    end
  end

endmodule

`default_nettype wire
